// ===== rtl/ostt_pkg.sv =====
// ----------------------------------------------------------------------------
// ostt_pkg: shared types and codes of the one-shot token table
// Command and status codes, the queued transaction and the slot entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package ostt_pkg;

	// request commands
	localparam logic [1:0] CMD_MINT    = 2'd0;
	localparam logic [1:0] CMD_CONSUME = 2'd1;
	localparam logic [1:0] CMD_REVOKE  = 2'd2;

	// result status codes
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_INVALID    = 3'd1;
	localparam logic [2:0] ST_FULL       = 3'd2;
	localparam logic [2:0] ST_BAD_HANDLE = 3'd3;
	localparam logic [2:0] ST_REVOKED    = 3'd4;
	localparam logic [2:0] ST_DENIED     = 3'd5;
	localparam logic [2:0] ST_EXPIRED    = 3'd6;

	// free-slot search works on groups of this many slots
	localparam int GRP_W    = 32;
	localparam int GRP_BITS = 5;

	// depth of the queue between front and back
	localparam int QDEPTH = 2;

	// work the back end has to do for one transaction
	typedef enum logic [1:0] {
		OP_MINT,
		OP_CONSUME,
		OP_REVOKE,
		OP_REJECT
	} op_t;

	// classified transaction as held in the queue
	typedef struct packed {
		op_t         op;
		logic [2:0]  status;   // result of a rejected transaction
		logic [31:0] slot;     // handle slot field minus one
		logic [31:0] gen;      // handle generation field
		logic [31:0] pid;
		logic [63:0] cap;
		logic [63:0] nonce;
		logic [63:0] stamp;    // expiry for mint, current time for consume
	} item_t;

	// one slot of the table memory
	typedef struct packed {
		logic [31:0] gen;
		logic [31:0] owner;
		logic [63:0] cap;
		logic [63:0] nonce;
		logic [63:0] expiry;
	} entry_t;

	// queue status seen by the front and the back
	typedef struct packed {
		logic valid;
		logic full;
	} qstat_t;

endpackage

`default_nettype wire

// ===== rtl/ostt_ram.sv =====
// ----------------------------------------------------------------------------
// ostt_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ostt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/ostt_front.sv =====
// ----------------------------------------------------------------------------
// ostt_front: request intake and classification
// Holds the invalid process id register, accepts requests and sorts them
// into work for the back end or an immediate rejection.
// ----------------------------------------------------------------------------
`default_nettype none

module ostt_front #(
	parameter int SLOTS = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_wr_en,
	input  wire logic [31:0]    cfg_wr_data,
	input  wire logic           start,
	output logic                busy,
	input  wire logic [1:0]     cmd,
	input  wire logic [63:0]    token,
	input  wire logic [31:0]    process_id,
	input  wire logic [63:0]    capability,
	input  wire logic [63:0]    op_nonce,
	input  wire logic [63:0]    expiry_time,
	input  wire logic [63:0]    now,
	input  ostt_pkg::qstat_t    q_stat,
	input  wire logic           clearing,
	output logic                push,
	output ostt_pkg::item_t     item
);

	import ostt_pkg::*;

	localparam logic [31:0] SLOT_LIMIT = 32'(SLOTS);

	logic [31:0] inv_pid_q;
	logic [31:0] low;
	logic        pid_bad;
	logic        cred_bad;
	logic        handle_bad;

	// hold the invalid process id register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_pid_q <= '0;
		end else if (cfg_wr_en) begin
			inv_pid_q <= cfg_wr_data;
		end
	end

	// take a transaction whenever the queue has room and the table is ready
	assign busy = q_stat.full || clearing;
	assign push = start && !busy;

	assign low        = token[31:0];
	assign pid_bad    = (process_id == inv_pid_q);
	assign cred_bad   = (capability == '0) || (op_nonce == '0);
	assign handle_bad = (low == '0) || (low > SLOT_LIMIT) || (token[63:32] == '0);

	// classify the request
	always_comb begin
		item.op     = OP_REJECT;
		item.status = ST_INVALID;
		item.slot   = low - 32'd1;
		item.gen    = token[63:32];
		item.pid    = process_id;
		item.cap    = capability;
		item.nonce  = op_nonce;
		item.stamp  = (cmd == CMD_MINT) ? expiry_time : now;
		case (cmd)
			CMD_MINT: begin
				if (!pid_bad && !cred_bad) begin
					item.op     = OP_MINT;
					item.status = ST_OK;
				end
			end
			CMD_CONSUME: begin
				if (token == '0 || pid_bad || cred_bad) begin
					item.status = ST_INVALID;
				end else if (handle_bad) begin
					item.status = ST_BAD_HANDLE;
				end else begin
					item.op     = OP_CONSUME;
					item.status = ST_OK;
				end
			end
			CMD_REVOKE: begin
				if (token == '0 || pid_bad) begin
					item.status = ST_INVALID;
				end else if (handle_bad) begin
					item.status = ST_BAD_HANDLE;
				end else begin
					item.op     = OP_REVOKE;
					item.status = ST_OK;
				end
			end
			default: begin
				item.status = ST_INVALID;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/ostt_queue.sv =====
// ----------------------------------------------------------------------------
// ostt_queue: short transaction queue between front and back
// Circular buffer of classified transactions; the front pushes, the back pops.
// ----------------------------------------------------------------------------
`default_nettype none

module ostt_queue (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  ostt_pkg::item_t  push_item,
	input  wire logic        pop,
	output ostt_pkg::item_t  head,
	output ostt_pkg::qstat_t stat
);

	import ostt_pkg::*;

	localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	item_t          mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// store the payload
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	assign head       = mem_q[rd_ptr_q];
	assign stat.valid = (count_q != '0);
	assign stat.full  = (count_q == (QAW + 1)'(QDEPTH));

	// the count never passes the depth, and a pop only meets a filled queue
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QAW + 1)'(QDEPTH))
		else $error("queue count beyond depth");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> stat.valid)
		else $error("pop from empty queue");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> !stat.full)
		else $error("push into full queue");

endmodule

`default_nettype wire

// ===== rtl/ostt_back.sv =====
// ----------------------------------------------------------------------------
// ostt_back: table engine
// Runs queued transactions against the slot table: free-slot search, entry
// read, checks and write-back. Clears the table memory after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ostt_back #(
	parameter int SLOTS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  ostt_pkg::qstat_t q_stat,
	input  ostt_pkg::item_t  head,
	output logic             pop,
	output logic             clearing,
	output logic             done,
	output logic [2:0]       status,
	output logic [63:0]      token_out
);

	import ostt_pkg::*;

	localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int NG   = (SLOTS + GRP_W - 1) / GRP_W;
	localparam int GW   = (NG > 1) ? $clog2(NG) : 1;
	localparam int PADN = NG * GRP_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FIND,
		S_EXEC
	} state_t;

	state_t                   state_q;
	logic                     clr_q;
	logic [SW-1:0]            clr_idx_q;
	logic [SLOTS-1:0]         active_q;
	logic                     done_q;
	logic [2:0]               status_q;
	logic [63:0]              token_q;
	item_t                    cur_q;
	logic [SW-1:0]            slot_q;
	logic [GW-1:0]            grp_q;

	logic [PADN-1:0]          free_pad;
	logic [NG-1:0]            grp_free;
	logic                     any_free;
	logic [GW-1:0]            grp_pick;
	logic [GRP_W-1:0]         grp_bits;
	logic [GRP_BITS-1:0]      bit_pick;
	logic [GW+GRP_BITS-1:0]   pick_full;
	logic [SW-1:0]            slot_pick;

	logic                     ram_we;
	logic [SW-1:0]            ram_waddr;
	entry_t                   ram_wdata;
	logic [SW-1:0]            ram_raddr;
	entry_t                   ram_rdata;

	logic [31:0]              gen_new;
	logic [2:0]               exec_st;

	// free map, padded to whole groups
	always_comb begin
		free_pad = '0;
		for (int i = 0; i < SLOTS; i++) begin
			free_pad[i] = !active_q[i];
		end
	end

	for (genvar g = 0; g < NG; g++) begin : g_grp
		assign grp_free[g] = |free_pad[g*GRP_W +: GRP_W];
	end

	assign any_free = |grp_free;

	// first group with a free slot
	always_comb begin
		grp_pick = '0;
		for (int g = NG - 1; g >= 0; g--) begin
			if (grp_free[g]) begin
				grp_pick = GW'(g);
			end
		end
	end

	// first free slot within the chosen group
	assign grp_bits = free_pad[grp_q*GRP_W +: GRP_W];

	always_comb begin
		bit_pick = '0;
		for (int b = GRP_W - 1; b >= 0; b--) begin
			if (grp_bits[b]) begin
				bit_pick = GRP_BITS'(b);
			end
		end
	end

	assign pick_full = {grp_q, bit_pick};
	assign slot_pick = pick_full[SW-1:0];

	// take the next transaction only when idle and the table is cleared
	assign pop      = (state_q == S_IDLE) && !clr_q && q_stat.valid;
	assign clearing = clr_q;

	assign ram_raddr = (state_q == S_FIND) ? slot_pick : head.slot[SW-1:0];

	// check the entry read for this transaction
	assign gen_new = (ram_rdata.gen == '0) ? 32'd1 : ram_rdata.gen;

	always_comb begin
		if (!active_q[slot_q] || ram_rdata.gen != cur_q.gen) begin
			exec_st = ST_REVOKED;
		end else if (ram_rdata.owner != cur_q.pid ||
				(cur_q.op == OP_CONSUME &&
				(ram_rdata.cap != cur_q.cap || ram_rdata.nonce != cur_q.nonce))) begin
			exec_st = ST_DENIED;
		end else if (cur_q.op == OP_CONSUME && ram_rdata.expiry != '0 &&
				cur_q.stamp >= ram_rdata.expiry) begin
			exec_st = ST_EXPIRED;
		end else begin
			exec_st = ST_OK;
		end
	end

	// write port: clearing pass, minted entry or freed entry
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = slot_q;
		ram_wdata = '0;
		if (clr_q) begin
			ram_we        = 1'b1;
			ram_waddr     = clr_idx_q;
			ram_wdata.gen = 32'd1;
		end else if (state_q == S_EXEC) begin
			if (cur_q.op == OP_MINT) begin
				ram_we           = 1'b1;
				ram_wdata.gen    = gen_new;
				ram_wdata.owner  = cur_q.pid;
				ram_wdata.cap    = cur_q.cap;
				ram_wdata.nonce  = cur_q.nonce;
				ram_wdata.expiry = cur_q.stamp;
			end else if (exec_st == ST_OK) begin
				ram_we        = 1'b1;
				ram_wdata.gen = ram_rdata.gen + 32'd1;
			end
		end
	end

	ostt_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (SLOTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sequencer, active bits, clearing pass and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
			active_q  <= '0;
			done_q    <= 1'b0;
			status_q  <= ST_OK;
			token_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (clr_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == SW'(SLOTS - 1)) begin
					clr_q <= 1'b0;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						case (head.op)
							OP_MINT: begin
								if (any_free) begin
									state_q <= S_FIND;
								end else begin
									done_q   <= 1'b1;
									status_q <= ST_FULL;
									token_q  <= '0;
								end
							end
							OP_CONSUME, OP_REVOKE: begin
								state_q <= S_EXEC;
							end
							default: begin
								done_q   <= 1'b1;
								status_q <= head.status;
								token_q  <= '0;
							end
						endcase
					end
				end
				S_FIND: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
					if (cur_q.op == OP_MINT) begin
						status_q         <= ST_OK;
						token_q          <= {gen_new, 32'(slot_q) + 32'd1};
						active_q[slot_q] <= 1'b1;
					end else begin
						status_q <= exec_st;
						token_q  <= '0;
						if (exec_st == ST_OK) begin
							active_q[slot_q] <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// hold the transaction, slot and search group under work
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q  <= head;
			slot_q <= head.slot[SW-1:0];
			grp_q  <= grp_pick;
		end else if (state_q == S_FIND) begin
			slot_q <= slot_pick;
		end
	end

	assign done      = done_q;
	assign status    = status_q;
	assign token_out = token_q;

	a_no_done_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !done_q)
		else $error("result during clearing pass");
	a_fail_zero_token: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q != ST_OK) |-> (token_q == '0))
		else $error("token on failed transaction");
	a_mint_handle: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && token_q != '0) |-> (token_q[31:0] != '0 && token_q[63:32] != '0))
		else $error("minted handle with zero field");
	a_find_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIND) |=> (state_q == S_EXEC))
		else $error("search not followed by execution");

endmodule

`default_nettype wire

// ===== rtl/one_shot_token_table_top.sv =====
// ----------------------------------------------------------------------------
// one_shot_token_table_top: table of single-use tokens with generations
// Mint, consume and revoke of authorisation tokens held in SLOTS slots.
//
//  channel    | handshake              | payload
//  -----------+------------------------+-------------------------------------
//  request    | start / busy           | cmd, token, process_id, capability,
//             |                        | op_nonce, expiry_time, now
//  result     | done (one-cycle pulse) | status, token_out
//  config     | cfg_wr_en              | cfg_wr_data (invalid process id)
//
// A request is taken on a clock edge with start high and busy low and lands
// in a two-entry queue; the table engine answers a rejected request or a mint
// into a full table without a table access, runs consume and revoke as entry
// read, then check and write-back, and mint as group search, slot search, write.
// All of these share the single table memory port pair.
// After reset busy stays high while the table memory is cleared. Results
// cannot be held off; busy rises only when the queue is full or during clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module one_shot_token_table_top #(
	parameter int SLOTS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [31:0] cfg_wr_data,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  cmd,
	input  wire logic [63:0] token,
	input  wire logic [31:0] process_id,
	input  wire logic [63:0] capability,
	input  wire logic [63:0] op_nonce,
	input  wire logic [63:0] expiry_time,
	input  wire logic [63:0] now,
	output logic             done,
	output logic [2:0]       status,
	output logic [63:0]      token_out
);

	import ostt_pkg::*;

	qstat_t q_stat;
	item_t  push_item;
	item_t  head;
	logic   push;
	logic   pop;
	logic   clearing;

	ostt_front #(
		.SLOTS (SLOTS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.token        (token),
		.process_id   (process_id),
		.capability   (capability),
		.op_nonce     (op_nonce),
		.expiry_time  (expiry_time),
		.now          (now),
		.q_stat       (q_stat),
		.clearing     (clearing),
		.push         (push),
		.item         (push_item)
	);

	ostt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	ostt_back #(
		.SLOTS (SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.head      (head),
		.pop       (pop),
		.clearing  (clearing),
		.done      (done),
		.status    (status),
		.token_out (token_out)
	);

endmodule

`default_nettype wire
